### hdl/tpv_pkg.sv
// Shared types, constants and helper functions for the trapezoidal profile core.
`timescale 1ns / 1ps

package tpv_pkg;

   localparam int TIME_WIDTH = 16;
   localparam int DUR_W      = 16;
   localparam int ACC_W      = 15;
   localparam int CMP_W      = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;
   localparam int POS_W      = 32;
   localparam int VEL_W      = 48;
   localparam int CFG_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int NAXES      = 3;

   localparam int DIFF_W     = 33;              // magnitude of end - start
   localparam int DPROD_W    = 31;              // ta * (T - ta)
   localparam int PNUM_W     = 32;
   localparam int OPA_W      = 17;
   localparam int REM_W      = 32;              // divisor and remainder width
   localparam int QUO_W      = 50;
   localparam int NUM_W      = 65;
   localparam int QR_W       = QUO_W + 1;
   localparam int PSUM_W     = 37;

   localparam int DIV_STEPS  = QUO_W;
   localparam int LATENCY    = DIV_STEPS + 5;

   localparam logic [1:0] PH_ACCEL  = 2'd0;
   localparam logic [1:0] PH_CRUISE = 2'd1;
   localparam logic [1:0] PH_DECEL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TOTAL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_START_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START_Z = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_END_X   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_END_Y   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_END_Z   = 3'd7;

   localparam logic [DUR_W-1:0] TOTAL_RESET = 16'd1000;
   localparam logic [ACC_W-1:0] ACCEL_RESET = 15'd250;

   localparam logic [QR_W-1:0] VMAX_POS = 51'h0_7FFF_FFFF_FFFF;
   localparam logic [QR_W-1:0] VMAX_NEG = 51'h0_8000_0000_0000;

   typedef struct packed {
      logic       valid;
      logic [1:0] phase;
      logic       err;
   } side_type;

   typedef struct packed {
      logic [DUR_W-1:0]            total;
      logic [ACC_W-1:0]            accel;
      logic [NAXES-1:0][POS_W-1:0] start_pt;
      logic [NAXES-1:0][POS_W-1:0] end_pt;
   } cfg_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] nq;
   } div_type;

   // One restoring step: shift in the next numerator bit, emit one quotient bit.
   function automatic div_type div_step(div_type s, logic [REM_W-1:0] den);
      logic [REM_W:0] r2;
      logic [REM_W:0] diff;
      logic           ge;
      div_type        res;
      r2   = {s.rem, s.nq[QUO_W-1]};
      diff = r2 - {1'b0, den};
      ge   = (r2 >= {1'b0, den});
      res.rem = ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
      res.nq  = {s.nq[QUO_W-2:0], ge};
      return res;
   endfunction

   function automatic logic [VEL_W-1:0] sat48(logic [QR_W-1:0] mag, logic neg);
      logic [QR_W-1:0] m;
      logic [QR_W-1:0] n;
      if (neg) begin
         m = (mag > VMAX_NEG) ? VMAX_NEG : mag;
         n = -m;
         return n[VEL_W-1:0];
      end else begin
         m = (mag > VMAX_POS) ? VMAX_POS : mag;
         return m[VEL_W-1:0];
      end
   endfunction

endpackage

### hdl/trapezoidal_profile_3axis_core.sv
// Three-axis trapezoidal velocity profile core: settings registers and pipeline.
// A start transfer passes the front stages, the divider stages and the back stages to the rsp_valid strobe.
// Throughput: one time stamp per cycle while busy is low; the 50-stage divider pipeline sets the depth.
// The result is shown for one cycle only; the receiver cannot stall the pipeline.
// Synchronous active-high reset clears all valid bits and loads the default
// settings (1000-tick move, 250-tick ramps, start and end at zero).
`timescale 1ns / 1ps

module trapezoidal_profile_3axis_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [tpv_pkg::TIME_WIDTH-1:0]       req_time_tick,
   input  logic                                 csr_we,
   input  logic [tpv_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tpv_pkg::CFG_W-1:0]            csr_wdata,
   output logic                                 rsp_valid,
   output logic signed [tpv_pkg::POS_W-1:0]     rsp_pos_x,
   output logic signed [tpv_pkg::POS_W-1:0]     rsp_pos_y,
   output logic signed [tpv_pkg::POS_W-1:0]     rsp_pos_z,
   output logic signed [tpv_pkg::VEL_W-1:0]     rsp_vel_x,
   output logic signed [tpv_pkg::VEL_W-1:0]     rsp_vel_y,
   output logic signed [tpv_pkg::VEL_W-1:0]     rsp_vel_z,
   output logic signed [tpv_pkg::VEL_W-1:0]     rsp_acc_x,
   output logic signed [tpv_pkg::VEL_W-1:0]     rsp_acc_y,
   output logic signed [tpv_pkg::VEL_W-1:0]     rsp_acc_z,
   output logic [1:0]                           rsp_phase,
   output logic                                 rsp_profile_error
);
   import tpv_pkg::*;

   cfg_type  cfg_ff;
   logic     busy_ff;
   logic     accept;

   side_type front_side;
   side_type side_ff [DIV_STEPS];
   side_type back_side;
   logic [NAXES-1:0][NUM_W-1:0] num_pos, num_vel, num_acc;
   logic [DPROD_W-1:0]          dprod;
   logic [NAXES-1:0]            neg;
   logic [NAXES-1:0][QUO_W-1:0] q_pos, q_vel, q_acc;
   logic [NAXES-1:0][REM_W-1:0] r_pos, r_vel, r_acc;
   logic [NAXES-1:0][POS_W-1:0] pos;
   logic [NAXES-1:0][VEL_W-1:0] vel, acc;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         cfg_ff.total    <= TOTAL_RESET;
         cfg_ff.accel    <= ACCEL_RESET;
         cfg_ff.start_pt <= '0;
         cfg_ff.end_pt   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TOTAL:   cfg_ff.total       <= csr_wdata[DUR_W-1:0];
            REG_ACCEL:   cfg_ff.accel       <= csr_wdata[ACC_W-1:0];
            REG_START_X: cfg_ff.start_pt[0] <= csr_wdata;
            REG_START_Y: cfg_ff.start_pt[1] <= csr_wdata;
            REG_START_Z: cfg_ff.start_pt[2] <= csr_wdata;
            REG_END_X:   cfg_ff.end_pt[0]   <= csr_wdata;
            REG_END_Y:   cfg_ff.end_pt[1]   <= csr_wdata;
            REG_END_Z:   cfg_ff.end_pt[2]   <= csr_wdata;
         endcase
      end
   end

   tpv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .time_tick (req_time_tick),
      .cfg       (cfg_ff),
      .side_out  (front_side),
      .num_pos   (num_pos),
      .num_vel   (num_vel),
      .num_acc   (num_acc),
      .dprod     (dprod),
      .neg       (neg)
   );

   // side info rides alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            side_ff[i] <= '0;
         end
      end else begin
         side_ff[0] <= front_side;
         for (int i = 1; i < DIV_STEPS; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   for (genvar k = 0; k < NAXES; k++) begin : g_axis
      tpv_div u_div_pos (
         .clock   (clock),
         .num_in  (num_pos[k]),
         .den_in  ({dprod, 1'b0}),
         .quo_out (q_pos[k]),
         .rem_out (r_pos[k])
      );
      tpv_div u_div_vel (
         .clock   (clock),
         .num_in  (num_vel[k]),
         .den_in  ({1'b0, dprod}),
         .quo_out (q_vel[k]),
         .rem_out (r_vel[k])
      );
      tpv_div u_div_acc (
         .clock   (clock),
         .num_in  (num_acc[k]),
         .den_in  ({1'b0, dprod}),
         .quo_out (q_acc[k]),
         .rem_out (r_acc[k])
      );
   end

   tpv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .side_in  (side_ff[DIV_STEPS-1]),
      .cfg      (cfg_ff),
      .dprod    (dprod),
      .neg      (neg),
      .q_pos    (q_pos),
      .r_pos    (r_pos),
      .q_vel    (q_vel),
      .r_vel    (r_vel),
      .q_acc    (q_acc),
      .r_acc    (r_acc),
      .side_out (back_side),
      .pos      (pos),
      .vel      (vel),
      .acc      (acc)
   );

   assign rsp_valid         = back_side.valid;
   assign rsp_phase         = back_side.phase;
   assign rsp_profile_error = back_side.err;
   assign rsp_pos_x         = pos[0];
   assign rsp_pos_y         = pos[1];
   assign rsp_pos_z         = pos[2];
   assign rsp_vel_x         = vel[0];
   assign rsp_vel_y         = vel[1];
   assign rsp_vel_z         = vel[2];
   assign rsp_acc_x         = acc[0];
   assign rsp_acc_y         = acc[1];
   assign rsp_acc_z         = acc[2];

endmodule

### hdl/tpv_front.sv
// Front stages: time clamp, phase select, profile terms and dividend products.
`timescale 1ns / 1ps

module tpv_front (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  logic [tpv_pkg::TIME_WIDTH-1:0]             time_tick,
   input  tpv_pkg::cfg_type                           cfg,
   output tpv_pkg::side_type                          side_out,
   output logic [tpv_pkg::NAXES-1:0][tpv_pkg::NUM_W-1:0] num_pos,
   output logic [tpv_pkg::NAXES-1:0][tpv_pkg::NUM_W-1:0] num_vel,
   output logic [tpv_pkg::NAXES-1:0][tpv_pkg::NUM_W-1:0] num_acc,
   output logic [tpv_pkg::DPROD_W-1:0]                dprod,
   output logic [tpv_pkg::NAXES-1:0]                  neg
);
   import tpv_pkg::*;

   logic [CMP_W-1:0]   t_ext;
   logic [CMP_W-1:0]   tot_ext;
   logic [DUR_W-1:0]   tc_in;
   logic [DUR_W-1:0]   tma_in;
   logic [DUR_W-1:0]   acc_ext;
   side_type           s1_side_in;

   side_type           s1_side_ff, s2_side_ff, s3_side_ff;
   logic [DUR_W-1:0]   tc_ff, tmt_ff;
   logic [OPA_W-1:0]   opa;
   logic [DUR_W-1:0]   opb;
   logic [DUR_W-1:0]   vk_in;
   logic [PNUM_W-1:0]  pnum_ff;
   logic [DUR_W-1:0]   vk_ff;
   logic [DPROD_W-1:0] d_ff;
   logic [NAXES-1:0][DIFF_W-1:0] m_ff;
   logic [NAXES-1:0]   neg_ff;
   logic [NAXES-1:0][NUM_W-1:0] num_pos_ff, num_vel_ff, num_acc_ff;

   always_comb begin
      t_ext   = CMP_W'(time_tick);
      tot_ext = CMP_W'(cfg.total);
      acc_ext = DUR_W'(cfg.accel);
      tc_in   = (t_ext > tot_ext) ? cfg.total : t_ext[DUR_W-1:0];
      tma_in  = cfg.total - acc_ext;
      s1_side_in.valid = in_valid;
      s1_side_in.err   = (cfg.accel == '0) ||
                         ((DUR_W+1)'({cfg.accel, 1'b0}) > {1'b0, cfg.total});
      if (tc_in <= acc_ext) begin
         s1_side_in.phase = PH_ACCEL;
      end else if (tc_in <= tma_in) begin
         s1_side_in.phase = PH_CRUISE;
      end else begin
         s1_side_in.phase = PH_DECEL;
      end
   end

   // operand select for the position and velocity numerators
   always_comb begin
      unique case (s1_side_ff.phase)
         PH_ACCEL: begin
            opa   = OPA_W'(tc_ff);
            opb   = tc_ff;
            vk_in = tc_ff;
         end
         PH_CRUISE: begin
            opa   = OPA_W'({tc_ff, 1'b0}) - OPA_W'(cfg.accel);
            opb   = DUR_W'(cfg.accel);
            vk_in = DUR_W'(cfg.accel);
         end
         PH_DECEL: begin
            opa   = OPA_W'(tmt_ff);
            opb   = tmt_ff;
            vk_in = tmt_ff;
         end
         default: begin
            opa   = '0;
            opb   = '0;
            vk_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff <= '0;
         s2_side_ff <= '0;
         s3_side_ff <= '0;
      end else begin
         s1_side_ff <= s1_side_in;
         s2_side_ff <= s1_side_ff;
         s3_side_ff <= s2_side_ff;
      end
      tc_ff   <= tc_in;
      tmt_ff  <= cfg.total - tc_in;
      pnum_ff <= PNUM_W'(opa * (OPA_W + DUR_W)'(opb));
      vk_ff   <= vk_in;
      // settings-only terms; the user must keep them stable while items are in flight (not enforced)
      d_ff    <= DPROD_W'(cfg.accel * tma_in);
      for (int k = 0; k < NAXES; k++) begin
         logic [DIFF_W-1:0] diff;
         diff = DIFF_W'($signed(cfg.end_pt[k])) - DIFF_W'($signed(cfg.start_pt[k]));
         neg_ff[k] <= diff[DIFF_W-1];
         m_ff[k]   <= diff[DIFF_W-1] ? -diff : diff;
         num_pos_ff[k] <= NUM_W'(m_ff[k]) * NUM_W'(pnum_ff);
         num_vel_ff[k] <= {(NUM_W-16)'(NUM_W'(m_ff[k]) * NUM_W'(vk_ff)), 16'd0};
         num_acc_ff[k] <= {16'd0, m_ff[k], 16'd0};
      end
   end

   assign side_out = s3_side_ff;
   assign num_pos  = num_pos_ff;
   assign num_vel  = num_vel_ff;
   assign num_acc  = num_acc_ff;
   assign dprod    = d_ff;
   assign neg      = neg_ff;

endmodule

### hdl/tpv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module tpv_div (
   input  logic                        clock,
   input  logic [tpv_pkg::NUM_W-1:0]   num_in,
   input  logic [tpv_pkg::REM_W-1:0]   den_in,
   output logic [tpv_pkg::QUO_W-1:0]   quo_out,
   output logic [tpv_pkg::REM_W-1:0]   rem_out
);
   import tpv_pkg::*;

   div_type head_in;
   div_type stage_ff [DIV_STEPS];

   // upper dividend bits are below the divisor for every valid profile
   always_comb begin
      head_in.rem = REM_W'(num_in[NUM_W-1:QUO_W]);
      head_in.nq  = num_in[QUO_W-1:0];
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= div_step(head_in, den_in);
      for (int i = 1; i < DIV_STEPS; i++) begin
         stage_ff[i] <= div_step(stage_ff[i-1], den_in);
      end
   end

   assign quo_out = stage_ff[DIV_STEPS-1].nq;
   assign rem_out = stage_ff[DIV_STEPS-1].rem;

endmodule

### hdl/tpv_back.sv
// Back stages: rounding, sign, saturation and position assembly.
`timescale 1ns / 1ps

module tpv_back (
   input  logic                                          clock,
   input  logic                                          reset,
   input  tpv_pkg::side_type                             side_in,
   input  tpv_pkg::cfg_type                              cfg,
   input  logic [tpv_pkg::DPROD_W-1:0]                   dprod,
   input  logic [tpv_pkg::NAXES-1:0]                     neg,
   input  logic [tpv_pkg::NAXES-1:0][tpv_pkg::QUO_W-1:0] q_pos,
   input  logic [tpv_pkg::NAXES-1:0][tpv_pkg::REM_W-1:0] r_pos,
   input  logic [tpv_pkg::NAXES-1:0][tpv_pkg::QUO_W-1:0] q_vel,
   input  logic [tpv_pkg::NAXES-1:0][tpv_pkg::REM_W-1:0] r_vel,
   input  logic [tpv_pkg::NAXES-1:0][tpv_pkg::QUO_W-1:0] q_acc,
   input  logic [tpv_pkg::NAXES-1:0][tpv_pkg::REM_W-1:0] r_acc,
   output tpv_pkg::side_type                             side_out,
   output logic [tpv_pkg::NAXES-1:0][tpv_pkg::POS_W-1:0] pos,
   output logic [tpv_pkg::NAXES-1:0][tpv_pkg::VEL_W-1:0] vel,
   output logic [tpv_pkg::NAXES-1:0][tpv_pkg::VEL_W-1:0] acc
);
   import tpv_pkg::*;

   logic [REM_W-1:0] den_p, den_d;
   side_type         b1_side_ff, b2_side_ff;
   logic [NAXES-1:0][QR_W-1:0]  qp_ff, qv_ff, qa_ff;
   logic [NAXES-1:0][POS_W-1:0] pos_ff;
   logic [NAXES-1:0][VEL_W-1:0] vel_ff, acc_ff;

   assign den_p = {dprod, 1'b0};
   assign den_d = {1'b0, dprod};

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_side_ff <= '0;
         b2_side_ff <= '0;
      end else begin
         b1_side_ff <= side_in;
         b2_side_ff <= {b1_side_ff.valid,
                        (b1_side_ff.err ? PH_ACCEL : b1_side_ff.phase),
                        b1_side_ff.err};
      end
      // round half away from zero on the magnitude
      for (int k = 0; k < NAXES; k++) begin
         qp_ff[k] <= QR_W'(q_pos[k]) + QR_W'({r_pos[k], 1'b0} >= {1'b0, den_p});
         qv_ff[k] <= QR_W'(q_vel[k]) + QR_W'({r_vel[k], 1'b0} >= {1'b0, den_d});
         qa_ff[k] <= QR_W'(q_acc[k]) + QR_W'({r_acc[k], 1'b0} >= {1'b0, den_d});
      end
      for (int k = 0; k < NAXES; k++) begin
         logic signed [PSUM_W-1:0] qs;
         logic signed [PSUM_W-1:0] base;
         logic signed [PSUM_W-1:0] psum;
         qs   = $signed({2'b00, qp_ff[k][PSUM_W-3:0]});
         qs   = neg[k] ? -qs : qs;
         if (b1_side_ff.phase == PH_DECEL) begin
            base = PSUM_W'($signed(cfg.end_pt[k]));
            psum = base - qs;
         end else begin
            base = PSUM_W'($signed(cfg.start_pt[k]));
            psum = base + qs;
         end
         if (b1_side_ff.err) begin
            pos_ff[k] <= '0;
            vel_ff[k] <= '0;
            acc_ff[k] <= '0;
         end else begin
            pos_ff[k] <= psum[POS_W-1:0];
            vel_ff[k] <= sat48(qv_ff[k], neg[k]);
            unique case (b1_side_ff.phase)
               PH_ACCEL:  acc_ff[k] <= sat48(qa_ff[k], neg[k]);
               PH_DECEL:  acc_ff[k] <= sat48(qa_ff[k], !neg[k]);
               default:   acc_ff[k] <= '0;
            endcase
         end
      end
   end

   assign side_out = b2_side_ff;
   assign pos      = pos_ff;
   assign vel      = vel_ff;
   assign acc      = acc_ff;

endmodule

### hdl/tpv_checker.sv
// Port-level checker for the trapezoidal profile core, with its bind.
`timescale 1ns / 1ps

module tpv_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic signed [tpv_pkg::POS_W-1:0]  rsp_pos_x,
   input logic signed [tpv_pkg::POS_W-1:0]  rsp_pos_y,
   input logic signed [tpv_pkg::POS_W-1:0]  rsp_pos_z,
   input logic signed [tpv_pkg::VEL_W-1:0]  rsp_vel_x,
   input logic signed [tpv_pkg::VEL_W-1:0]  rsp_vel_y,
   input logic signed [tpv_pkg::VEL_W-1:0]  rsp_vel_z,
   input logic signed [tpv_pkg::VEL_W-1:0]  rsp_acc_x,
   input logic signed [tpv_pkg::VEL_W-1:0]  rsp_acc_y,
   input logic signed [tpv_pkg::VEL_W-1:0]  rsp_acc_z,
   input logic [1:0]                        rsp_phase,
   input logic                              rsp_profile_error
);
   import tpv_pkg::*;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("transfer did not produce a result at fixed latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching input transfer");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_profile_error |->
         rsp_pos_x == 0 && rsp_pos_y == 0 && rsp_pos_z == 0 &&
         rsp_vel_x == 0 && rsp_vel_y == 0 && rsp_vel_z == 0 &&
         rsp_acc_x == 0 && rsp_acc_y == 0 && rsp_acc_z == 0 &&
         rsp_phase == PH_ACCEL)
      else $error("invalid profile result not cleared");

   a_cruise_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_CRUISE |->
         rsp_acc_x == 0 && rsp_acc_y == 0 && rsp_acc_z == 0)
      else $error("nonzero acceleration while cruising");

   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phase == PH_ACCEL || rsp_phase == PH_CRUISE ||
                    rsp_phase == PH_DECEL)
      else $error("undefined phase code on result");

endmodule

bind trapezoidal_profile_3axis_core tpv_checker u_tpv_checker (.*);
